[hdl/spc_pkg.sv]
// ----------------------------------------------------------------------------
// Sprite pixel collision package
// Shared constants for the sprite pixel collision unit.
// ----------------------------------------------------------------------------
package spc_pkg;

  localparam int unsigned MaxSpritePixels = 4096;

  localparam logic [1:0] KIND_LOAD_FIRST  = 2'd0;
  localparam logic [1:0] KIND_LOAD_SECOND = 2'd1;
  localparam logic [1:0] KIND_DETECT      = 2'd2;

  localparam logic [1:0] VERDICT_NONE    = 2'd0;
  localparam logic [1:0] VERDICT_BOXES   = 2'd1;
  localparam logic [1:0] VERDICT_COLLIDE = 2'd2;

  localparam logic [2:0] REG_CELL_W  = 3'd0;
  localparam logic [2:0] REG_CELL_H  = 3'd1;
  localparam logic [2:0] REG_FIRST_W = 3'd2;
  localparam logic [2:0] REG_FIRST_H = 3'd3;
  localparam logic [2:0] REG_SEC_W   = 3'd4;
  localparam logic [2:0] REG_SEC_H   = 3'd5;

endpackage

[hdl/sprite_pixel_collision_unit.sv]
// ----------------------------------------------------------------------------
// Sprite pixel collision unit
// Pixel-exact collision test between a moving sprite and an obstacle sprite.
// ----------------------------------------------------------------------------
// Input words arrive on in_valid/in_stall with the item fields as ports.
// Load words (kind 0 or 1) store one opaque bit per raw pixel in one of two
// 4096-entry bit memories; a load does not raise in_stall. A detect word
// places two cell-sized boxes and, if they overlap, walks the overlap
// rectangle pixel by pixel. Each pixel needs four raw coordinates from one
// shared serial divider; one division loads its operands, works out 15
// quotient bits and signals done. The address, memory read and check steps
// follow, and each row of the walk adds a step. A detect whose boxes miss
// goes from S_SETUP straight to its result; otherwise the result follows
// the walk, which stops at the first collision. The result word
// appears on out_valid and is held while out_stall is high; in_stall stays
// high from the cycle after a detect is taken until its result word has
// been accepted. Writes use cfg_valid and cfg_ready (always ready) with
// a register index. Reset restores the register defaults; the opaque
// memories are not cleared and read as undefined until written.
// ----------------------------------------------------------------------------
module sprite_pixel_collision_unit
  import spc_pkg::*;
#(
  parameter int unsigned MAX_SPRITE_PIXELS = MaxSpritePixels
)(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         kind,
  input  logic [11:0]        pixel_index,
  input  logic [31:0]        pixel_word,
  input  logic [11:0]        first_center_x,
  input  logic [11:0]        first_center_y,
  input  logic [11:0]        second_center_x,
  input  logic [11:0]        second_center_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         verdict,
  output logic signed [13:0] overlap_left,
  output logic signed [13:0] overlap_right,
  output logic signed [13:0] overlap_top,
  output logic signed [13:0] overlap_bottom,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [7:0]         cfg_data
);

  localparam int AW = $clog2(MAX_SPRITE_PIXELS);

  logic [7:0] cell_w, cell_h;
  logic [6:0] first_w, first_h, sec_w, sec_h;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_w <= 8'd32;
      cell_h <= 8'd32;
      first_w <= 7'd64;
      first_h <= 7'd64;
      sec_w <= 7'd64;
      sec_h <= 7'd64;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CELL_W:  cell_w <= cfg_data;
        REG_CELL_H:  cell_h <= cfg_data;
        REG_FIRST_W: first_w <= cfg_data[6:0];
        REG_FIRST_H: first_h <= cfg_data[6:0];
        REG_SEC_W:   sec_w <= cfg_data[6:0];
        REG_SEC_H:   sec_h <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Opaque bit memories.
  logic first_mem [MAX_SPRITE_PIXELS];
  logic second_mem [MAX_SPRITE_PIXELS];
  logic first_rd, second_rd;
  logic [AW-1:0] rd_first_addr, rd_second_addr;

  typedef enum logic [3:0] {
    S_IDLE, S_SETUP, S_PIX, S_DIV_FX, S_DIV_FY, S_DIV_SX, S_DIV_SY,
    S_INDEX, S_READ, S_CHECK, S_OUT
  } state_t;
  state_t state;

  logic accept;
  assign in_stall = (state != S_IDLE);
  assign accept = in_valid && !in_stall;

  logic [7:0] cw, ch;
  logic signed [13:0] ax, ay, bx, by, left, right, top, bottom, x, y;
  logic [6:0] fx, fy, sx, sy;
  logic [19:0] fidx, sidx;
  logic        fok, sok;

  // Shared divider.
  logic       dv_start, dv_done;
  logic [7:0] dv_off, dv_cell;
  logic [6:0] dv_raw, dv_q;

  spc_scaler u_scaler (
    .clk(clk), .rst(rst), .start(dv_start), .offset(dv_off), .raw(dv_raw),
    .cell_size(dv_cell), .done(dv_done), .quot(dv_q)
  );

  always_comb begin
    dv_off = 8'(x - ax);
    dv_raw = first_w;
    dv_cell = cw;
    case (state)
      S_DIV_FY: begin dv_off = 8'(y - ay); dv_raw = first_h; dv_cell = ch; end
      S_DIV_SX: begin dv_off = 8'(x - bx); dv_raw = sec_w; end
      S_DIV_SY: begin dv_off = 8'(y - by); dv_raw = sec_h; dv_cell = ch; end
      default: ;
    endcase
  end

  logic signed [13:0] ax_n, ay_n, bx_n, by_n;
  logic [7:0] cw_n, ch_n;
  always_comb begin
    cw_n = (cell_w == 8'd0) ? 8'd1 : cell_w;
    ch_n = (cell_h == 8'd0) ? 8'd1 : cell_h;
    ax_n = $signed({2'b00, first_center_x}) - $signed({7'd0, cw_n[7:1]});
    ay_n = $signed({2'b00, first_center_y}) - $signed({7'd0, ch_n[7:1]});
    bx_n = $signed({2'b00, second_center_x}) - $signed({7'd0, cw_n[7:1]});
    by_n = $signed({2'b00, second_center_y}) - $signed({7'd0, ch_n[7:1]});
  end

  logic signed [13:0] cws, chs;
  assign cws = $signed({6'd0, cw});
  assign chs = $signed({6'd0, ch});

  always_ff @(posedge clk) begin
    if (kind == KIND_LOAD_FIRST && accept && {20'd0, pixel_index} < 32'(MAX_SPRITE_PIXELS))
      first_mem[AW'(pixel_index)] <= (pixel_word[31:24] != 8'd0);
    if (kind == KIND_LOAD_SECOND && accept && {20'd0, pixel_index} < 32'(MAX_SPRITE_PIXELS))
      second_mem[AW'(pixel_index)] <= (pixel_word[31:24] != 8'd0);
    first_rd <= first_mem[rd_first_addr];
    second_rd <= second_mem[rd_second_addr];
  end

  assign rd_first_addr = AW'(fidx);
  assign rd_second_addr = AW'(sidx);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      dv_start <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          dv_start <= 1'b0;
          if (accept && kind == KIND_DETECT) begin
            cw <= cw_n; ch <= ch_n;
            ax <= ax_n; ay <= ay_n; bx <= bx_n; by <= by_n;
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          dv_start <= 1'b0;
          x <= (ax > bx) ? ax : bx;
          y <= (ay > by) ? ay : by;
          if ((ax <= bx && ax + cws < bx) || (bx <= ax && bx + cws < ax) ||
              (ay <= by && ay + chs < by) || (by <= ay && by + chs < ay)) begin
            verdict <= VERDICT_NONE;
            left <= '0; right <= '0; top <= '0; bottom <= '0;
            state <= S_OUT;
            out_valid <= 1'b1;
          end else begin
            verdict <= VERDICT_BOXES;
            left <= (ax > bx) ? ax : bx;
            right <= (ax < bx) ? ax + cws : bx + cws;
            top <= (ay > by) ? ay : by;
            bottom <= (ay < by) ? ay + chs : by + chs;
            state <= S_PIX;
          end
        end
        S_PIX: begin
          if (y >= bottom || x >= right && x == left) begin
            dv_start <= 1'b0;
            state <= S_OUT;
            out_valid <= 1'b1;
          end else if (x >= right) begin
            dv_start <= 1'b0;
            x <= left;
            y <= y + 14'sd1;
          end else begin
            dv_start <= 1'b1;
            state <= S_DIV_FX;
          end
        end
        S_DIV_FX: begin
          dv_start <= dv_done;
          if (dv_done) begin fx <= dv_q; state <= S_DIV_FY; end
        end
        S_DIV_FY: begin
          dv_start <= dv_done;
          if (dv_done) begin fy <= dv_q; state <= S_DIV_SX; end
        end
        S_DIV_SX: begin
          dv_start <= dv_done;
          if (dv_done) begin sx <= dv_q; state <= S_DIV_SY; end
        end
        S_DIV_SY: begin
          dv_start <= 1'b0;
          if (dv_done) begin sy <= dv_q; state <= S_INDEX; end
        end
        S_INDEX: begin
          dv_start <= 1'b0;
          fidx <= 20'(fy * first_w) + 20'(fx);
          sidx <= 20'(sy * sec_w) + 20'(sx);
          state <= S_READ;
        end
        S_READ: begin
          dv_start <= 1'b0;
          fok <= fidx < 20'(MAX_SPRITE_PIXELS);
          sok <= sidx < 20'(MAX_SPRITE_PIXELS);
          state <= S_CHECK;
        end
        S_CHECK: begin
          dv_start <= 1'b0;
          if (fok && sok && first_rd && second_rd) begin
            verdict <= VERDICT_COLLIDE;
            state <= S_OUT;
            out_valid <= 1'b1;
          end else begin
            x <= x + 14'sd1;
            state <= S_PIX;
          end
        end
        S_OUT: begin
          dv_start <= 1'b0;
          if (!out_stall) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: begin
          dv_start <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign overlap_left = left;
  assign overlap_right = right;
  assign overlap_top = top;
  assign overlap_bottom = bottom;

endmodule

[hdl/spc_scaler.sv]
// ----------------------------------------------------------------------------
// Sprite pixel collision scaler
// Shared multiply then restoring divider: q = floor(o * raw / cell_size),
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module spc_scaler
  import spc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [7:0]  offset,
  input  logic [6:0]  raw,
  input  logic [7:0]  cell_size,
  output logic        done,
  output logic [6:0]  quot
);

  // Product below 255*128 fits 15 bits; quotient < 128 if offset < cell_size.
  logic [14:0] dividend;
  logic [7:0]  divisor;
  logic [8:0]  rem;
  logic [3:0]  count;
  logic        busy;
  logic [8:0]  trial;
  logic [8:0]  shifted;

  always_comb begin
    shifted = {rem[7:0], dividend[14]};
    trial   = shifted - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      if (start) begin
        dividend <= {7'd0, offset} * {8'd0, raw};
        divisor <= cell_size;
        rem <= '0;
        count <= 4'd15;
        busy <= 1'b1;
        done <= 1'b0;
      end else if (busy) begin
        if (!trial[8]) begin
          rem <= trial;
          dividend <= {dividend[13:0], 1'b1};
        end else begin
          rem <= shifted;
          dividend <= {dividend[13:0], 1'b0};
        end
        count <= count - 4'd1;
        busy <= (count != 4'd1);
        done <= (count == 4'd1);
      end else begin
        done <= 1'b0;
      end
    end
  end

  assign quot = dividend[6:0];

endmodule

[verif/sprite_pixel_collision_checker.sv]
// ----------------------------------------------------------------------------
// Sprite pixel collision checker
// Watches the input, result and register channels of the collision unit,
// keeps its own copy of the opaque masks and registers, predicts every
// detect result and compares it field by field.
// ----------------------------------------------------------------------------
module sprite_pixel_collision_checker
  import spc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         kind,
  input  logic [11:0]        pixel_index,
  input  logic [31:0]        pixel_word,
  input  logic [11:0]        first_center_x,
  input  logic [11:0]        first_center_y,
  input  logic [11:0]        second_center_x,
  input  logic [11:0]        second_center_y,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [1:0]         verdict,
  input  logic signed [13:0] overlap_left,
  input  logic signed [13:0] overlap_right,
  input  logic signed [13:0] overlap_top,
  input  logic signed [13:0] overlap_bottom,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  output int                 errors,
  output int                 pending
);

  typedef struct packed {
    logic [1:0]         verdict;
    logic signed [13:0] left;
    logic signed [13:0] right;
    logic signed [13:0] top;
    logic signed [13:0] bottom;
  } overlap_result_t;

  bit         first_mask  [MaxSpritePixels];
  bit         second_mask [MaxSpritePixels];
  logic [7:0] cell_w, cell_h;
  logic [6:0] first_w, first_h, second_w, second_h;

  overlap_result_t expected_overlaps[$];

  initial errors = 0;
  initial pending = 0;

  function automatic int unsigned texel_index(int unsigned ox, int unsigned oy,
                                              int unsigned cw, int unsigned ch,
                                              int unsigned rw, int unsigned rh);
    return ((oy * rh) / ch) * rw + (ox * rw) / cw;
  endfunction

  function automatic overlap_result_t judge_overlap(int fx, int fy, int sx, int sy);
    overlap_result_t res;
    int cw, ch, ax, ay, bx, by, left, right, top, bottom;
    int unsigned pi, oi;
    bit hx, vy, hit;
    cw = (cell_w == 0) ? 1 : cell_w;
    ch = (cell_h == 0) ? 1 : cell_h;
    ax = fx - (cw >>> 1);
    ay = fy - (ch >>> 1);
    bx = sx - (cw >>> 1);
    by = sy - (ch >>> 1);
    hx = !((ax <= bx && ax + cw < bx) || (bx <= ax && bx + cw < ax));
    vy = !((ay <= by && ay + ch < by) || (by <= ay && by + ch < ay));
    res = '0;
    res.verdict = VERDICT_NONE;
    if (!(hx && vy)) return res;
    left   = (ax > bx) ? ax : bx;
    right  = (ax + cw < bx + cw) ? ax + cw : bx + cw;
    top    = (ay > by) ? ay : by;
    bottom = (ay + ch < by + ch) ? ay + ch : by + ch;
    hit = 0;
    for (int y = top; y < bottom && !hit; y++) begin
      for (int x = left; x < right && !hit; x++) begin
        pi = texel_index(x - ax, y - ay, cw, ch, first_w, first_h);
        oi = texel_index(x - bx, y - by, cw, ch, second_w, second_h);
        if (pi < MaxSpritePixels && oi < MaxSpritePixels)
          hit = first_mask[pi] && second_mask[oi];
      end
    end
    res.verdict = hit ? VERDICT_COLLIDE : VERDICT_BOXES;
    res.left    = left[13:0];
    res.right   = right[13:0];
    res.top     = top[13:0];
    res.bottom  = bottom[13:0];
    return res;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch on %s: got %0d, expected %0d", field, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    overlap_result_t want;
    if (rst) begin
      cell_w = 8'd32; cell_h = 8'd32;
      first_w = 7'd64; first_h = 7'd64;
      second_w = 7'd64; second_h = 7'd64;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_overlaps.size() == 0) begin
          report_mismatch("result words outstanding", 1, 0);
        end else begin
          want = expected_overlaps.pop_front();
          if (verdict !== want.verdict) report_mismatch("verdict", verdict, want.verdict);
          if (overlap_left !== want.left)
            report_mismatch("overlap_left", overlap_left, want.left);
          if (overlap_right !== want.right)
            report_mismatch("overlap_right", overlap_right, want.right);
          if (overlap_top !== want.top)
            report_mismatch("overlap_top", overlap_top, want.top);
          if (overlap_bottom !== want.bottom)
            report_mismatch("overlap_bottom", overlap_bottom, want.bottom);
        end
      end
      if (in_valid && !in_stall) begin
        if (kind == KIND_LOAD_FIRST)
          first_mask[pixel_index] = (pixel_word[31:24] != 8'd0);
        else if (kind == KIND_LOAD_SECOND)
          second_mask[pixel_index] = (pixel_word[31:24] != 8'd0);
        else if (kind == KIND_DETECT)
          expected_overlaps.push_back(judge_overlap(first_center_x, first_center_y,
                                                    second_center_x, second_center_y));
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CELL_W:  cell_w = cfg_data;
          REG_CELL_H:  cell_h = cfg_data;
          REG_FIRST_W: first_w = cfg_data[6:0];
          REG_FIRST_H: first_h = cfg_data[6:0];
          REG_SEC_W:   second_w = cfg_data[6:0];
          REG_SEC_H:   second_h = cfg_data[6:0];
          default: ;
        endcase
      end
    end
    pending = expected_overlaps.size();
  end

endmodule

[verif/sprite_pixel_collision_unit_test.sv]
// ----------------------------------------------------------------------------
// Sprite pixel collision unit testbench
// Fills the first 256 texels of both opaque masks, runs directed edge
// cases, then random phases of pixel loads and detect words under several
// register settings, with bursty input traffic and a stalling result receiver.
// ----------------------------------------------------------------------------
module sprite_pixel_collision_unit_test;
  import spc_pkg::*;

  // Kind code and register indexes that the block must ignore.
  localparam logic [1:0] KIND_UNUSED   = 2'd3;
  localparam logic [2:0] REG_UNUSED_LO = 3'd6;
  localparam logic [2:0] REG_UNUSED_HI = 3'd7;

  // A detect walks its overlap one pixel at a time; the bound below covers the
  // slowest legal run several times over.
  localparam int CycleLimit = 20_000_000;
  localparam int SettleCycles = 20;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         kind = '0;
  logic [11:0]        pixel_index = '0;
  logic [31:0]        pixel_word = '0;
  logic [11:0]        first_center_x = '0;
  logic [11:0]        first_center_y = '0;
  logic [11:0]        second_center_x = '0;
  logic [11:0]        second_center_y = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         verdict;
  logic signed [13:0] overlap_left, overlap_right, overlap_top, overlap_bottom;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [7:0]         cfg_data = '0;

  int errors, pending;
  int cycles = 0;
  int burst_left = 0;
  int words_sent = 0;
  int detects_sent = 0;
  int phases_run = 0;
  int cur_cell_w = 32;
  int cur_cell_h = 32;
  int opaque_pct = 50;

  always #5 clk = ~clk;

  sprite_pixel_collision_unit DUT (.*);

  sprite_pixel_collision_checker checker_inst (.*);

  // The run is bounded by a plain cycle count; hitting it means something hung.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // The receiver redraws its stall habit by the cycle count: sometimes it never
  // stalls, sometimes lightly, sometimes it holds off for long stretches.
  int stall_mode = 0;
  always @(posedge clk) begin
    if (cycles % 64 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 99) < 30);
      default: out_stall <= ($urandom_range(0, 99) < 85);
    endcase
  end

  // Sends one word. The sender works in bursts; between bursts it drops
  // valid for a random number of cycles.
  task automatic send_word(input logic [1:0] k, input logic [11:0] idx,
                           input logic [31:0] w, input logic [11:0] fx,
                           input logic [11:0] fy, input logic [11:0] sx,
                           input logic [11:0] sy);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    kind <= k;
    pixel_index <= idx;
    pixel_word <= w;
    first_center_x <= fx;
    first_center_y <= fy;
    second_center_x <= sx;
    second_center_y <= sy;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    words_sent++;
    if (k == KIND_DETECT) detects_sent++;
  endtask

  function automatic logic [31:0] random_pixel();
    logic [31:0] w;
    w = $urandom;
    if ($urandom_range(0, 99) >= opaque_pct) w[31:24] = 8'd0;
    else if (w[31:24] == 8'd0) w[31:24] = 8'd1;
    return w;
  endfunction

  task automatic send_load(input logic [1:0] k, input int idx, input logic [31:0] w);
    send_word(k, idx[11:0], w, 12'($urandom), 12'($urandom), 12'($urandom),
              12'($urandom));
  endtask

  task automatic send_detect(input int fx, input int fy, input int sx, input int sy);
    send_word(KIND_DETECT, 12'($urandom), $urandom, fx[11:0], fy[11:0], sx[11:0],
              sy[11:0]);
  endtask

  function automatic int clamp_screen(int v);
    if (v < 0) return 0;
    if (v > 4095) return 4095;
    return v;
  endfunction

  // Stops feeding, waits for every outstanding result, then lets the block
  // settle so that a trailing load is finished before registers change.
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input int cw, input int ch, input int frw, input int frh,
                            input int srw, input int srh);
    drain();
    write_reg(REG_CELL_W, cw[7:0]);
    write_reg(REG_CELL_H, ch[7:0]);
    write_reg(REG_FIRST_W, frw[7:0]);
    write_reg(REG_FIRST_H, frh[7:0]);
    write_reg(REG_SEC_W, srw[7:0]);
    write_reg(REG_SEC_H, srh[7:0]);
    cur_cell_w = (cw[7:0] == 0) ? 1 : cw[7:0];
    cur_cell_h = (ch[7:0] == 0) ? 1 : ch[7:0];
    phases_run++;
  endtask

  // Random traffic: mostly detects, most with boxes that land near each other,
  // plus loads into the used texel area and a little noise.
  task automatic random_traffic(input int n, input int area1, input int area2);
    int pick, fx, fy, sx, sy;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        fx = $urandom_range(0, 4095);
        fy = $urandom_range(0, 4095);
        sx = clamp_screen(fx + $urandom_range(0, 2 * cur_cell_w + 4) - (cur_cell_w + 2));
        sy = clamp_screen(fy + $urandom_range(0, 2 * cur_cell_h + 4) - (cur_cell_h + 2));
        send_detect(fx, fy, sx, sy);
      end else if (pick < 55) begin
        send_detect($urandom_range(0, 4095), $urandom_range(0, 4095),
                    $urandom_range(0, 4095), $urandom_range(0, 4095));
      end else if (pick < 75) begin
        send_load(KIND_LOAD_FIRST, $urandom_range(0, area1 - 1), random_pixel());
      end else if (pick < 95) begin
        send_load(KIND_LOAD_SECOND, $urandom_range(0, area2 - 1), random_pixel());
      end else if (pick < 98) begin
        send_load(2'($urandom_range(0, 1)), $urandom_range(0, 4095), random_pixel());
      end else begin
        send_word(KIND_UNUSED, 12'($urandom), $urandom, 12'($urandom), 12'($urandom),
                  12'($urandom), 12'($urandom));
      end
    end
  endtask

  initial begin
    int frw, frh, srw, srh;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Only the 127 by 127 setting uses a raw texture area above 256 texels, and
    // its detects read texels below 256 only, so writing the first 256 texels of
    // both masks once means no detect can ever read an entry with nothing defined.
    set_config(32, 32, 16, 16, 16, 16);
    for (int i = 0; i < 256; i++) begin
      send_load(KIND_LOAD_FIRST, i, random_pixel());
      send_load(KIND_LOAD_SECOND, i, random_pixel());
    end

    // Directed cases with full-size cells over 16 by 16 textures.
    send_load(KIND_LOAD_FIRST, 4095, 32'hFFFF_FFFF);
    send_load(KIND_LOAD_SECOND, 4095, 32'h00FF_FFFF);
    send_load(KIND_LOAD_FIRST, 0, 32'h0100_0000);
    send_load(KIND_LOAD_SECOND, 0, 32'h0000_0000);
    send_word(KIND_UNUSED, 12'hFFF, 32'hFFFF_FFFF, 12'd100, 12'd100, 12'd100, 12'd100);
    send_detect(2000, 2000, 2000, 2000);         // boxes fully on top of each other
    send_detect(0, 0, 0, 0);                     // corners hang off the screen origin
    send_detect(4095, 4095, 4095, 4095);         // far screen corner
    send_detect(0, 0, 4095, 4095);               // far apart
    send_detect(1000, 1000, 1032, 1000);         // touching on x, zero width
    send_detect(1000, 1000, 1000, 1032);         // touching on y, zero height
    send_detect(1000, 1000, 1033, 1000);         // one pixel apart on x
    send_detect(1000, 1000, 1000, 1033);         // one pixel apart on y
    send_detect(1000, 1000, 1031, 1031);         // single-pixel overlap
    send_detect(1031, 1031, 1000, 1000);         // same, roles swapped
    drain();

    // Extreme settings: widest cells with the thinnest overlaps, then the
    // smallest cells and textures, then zero cell size, which acts as one,
    // then the widest raw sizes that the register holds.
    set_config(255, 255, 16, 16, 16, 16);
    send_detect(1000, 1000, 1255, 1000);
    send_detect(1000, 1000, 1254, 1000);
    send_detect(1000, 1000, 1000, 1254);
    send_detect(0, 4095, 0, 4095 - 256);
    drain();
    write_reg(REG_UNUSED_LO, 8'hFF);
    write_reg(REG_UNUSED_HI, 8'h00);
    send_detect(1000, 1000, 1000, 1254);
    set_config(1, 1, 1, 1, 1, 1);
    random_traffic(40, 1, 1);
    set_config(0, 0, 64, 1, 1, 64);
    random_traffic(40, 64, 64);
    set_config(255, 1, 127, 127, 127, 127);
    send_detect(500, 500, 754, 500);
    send_detect(500, 500, 755, 500);

    // Random phases with small cells so that each detect walks few pixels.
    for (int p = 0; p < 8; p++) begin
      frw = $urandom_range(1, 16);
      frh = $urandom_range(1, 16);
      srw = $urandom_range(1, 16);
      srh = $urandom_range(1, 16);
      opaque_pct = $urandom_range(5, 95);
      set_config($urandom_range(1, 6), $urandom_range(1, 6), frw, frh, srw, srh);
      random_traffic(180, frw * frh, srw * srh);
    end
    set_config(32, 32, 16, 16, 16, 16);
    random_traffic(20, 256, 256);
    drain();

    $display("covered %0d words with %0d detects over %0d register settings",
             words_sent, detects_sent, phases_run);
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
